>>> hw/rtl/utf8_stream_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared property shapes for the port checker of the decoder.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_MACROS_SVH
`define UTF8_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("utf8 decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("utf8 decoder check failed");

// Next-cycle implication that is also checked through reset.
`define UTF8SD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("utf8 decoder check failed");

`endif

>>> hw/rtl/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Types, byte thresholds and error codes shared by the decoder modules.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int UTF8SD_QUEUE_DEPTH = 2;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;
    localparam int ERR_W = 2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_LEAD  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CONT  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

    localparam logic [LEN_W-1:0] LEN_BAD   = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    localparam logic [7:0] BYTE_ASCII_END = 8'h80;
    localparam logic [7:0] BYTE_TWO_START = 8'hC2;
    localparam logic [7:0] BYTE_THREE_START = 8'hE0;
    localparam logic [7:0] BYTE_FOUR_START = 8'hF0;
    localparam logic [7:0] BYTE_LEAD_END = 8'hF5;

    localparam logic [7:0] LEAD_E0 = 8'hE0;
    localparam logic [7:0] LEAD_F0 = 8'hF0;
    localparam logic [7:0] LEAD_F4 = 8'hF4;
    localparam logic [7:0] MIN_AFTER_E0 = 8'hA0;
    localparam logic [7:0] MIN_AFTER_F0 = 8'h90;
    localparam logic [7:0] MAX_AFTER_F4 = 8'h90;

    typedef struct packed {
        logic [7:0]       data;
        logic [LEN_W-1:0] lead_len;
        logic             is_cont;
    } cls_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             error;
        logic [ERR_W-1:0] error_kind;
    } res_t;

endpackage

>>> hw/rtl/utf8_stream_decoder_unit.sv
// Path: a byte that closes a sequence is queued, then the back end registers m_valid.
// Throughput: one byte per cycle in the back end decode step, unless m_ready stalls m_valid.
// The request queue lets the input keep flowing for its depth while the output stalls.
// Reset: synchronous, active low; clears the sequence state, the queue and the output valid.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit
// Decodes a byte stream into code points with length and error reporting.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
#(
    parameter int QUEUE_DEPTH = UTF8SD_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_in_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CP_W-1:0]  m_code_point,
    output logic [LEN_W-1:0] m_seq_length,
    output logic             m_error,
    output logic [ERR_W-1:0] m_error_kind
);

    logic push_valid, push_ready;
    cls_t push_cls;
    logic pop_valid, pop_ready;
    cls_t pop_cls;
    res_t m_res;

    utf8sd_front u_front (
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cls   (push_cls)
    );

    utf8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cls   (push_cls),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cls    (pop_cls)
    );

    utf8sd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cls   (pop_cls),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_code_point = m_res.code_point;
    assign m_seq_length = m_res.seq_length;
    assign m_error      = m_res.error;
    assign m_error_kind = m_res.error_kind;

endmodule

>>> hw/rtl/utf8sd_front.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts raw bytes and tags each with its lead length and continuation flag.
// ----------------------------------------------------------------------------
module utf8sd_front
    import utf8sd_pkg::*;
(
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output cls_t       push_cls
);

    logic [LEN_W-1:0] lead_len;

    always_comb begin
        if (s_in_byte < BYTE_ASCII_END) begin
            lead_len = LEN_ONE;
        end else if (s_in_byte < BYTE_TWO_START) begin
            lead_len = LEN_BAD;
        end else if (s_in_byte < BYTE_THREE_START) begin
            lead_len = LEN_TWO;
        end else if (s_in_byte < BYTE_FOUR_START) begin
            lead_len = LEN_THREE;
        end else if (s_in_byte < BYTE_LEAD_END) begin
            lead_len = LEN_FOUR;
        end else begin
            lead_len = LEN_BAD;
        end
    end

    // Input is held off while reset is asserted.
    assign s_ready             = push_ready & aresetn;
    assign push_valid          = s_valid & aresetn;
    assign push_cls.data       = s_in_byte;
    assign push_cls.lead_len   = lead_len;
    assign push_cls.is_cont    = (s_in_byte[7:6] == 2'b10);

endmodule

>>> hw/rtl/utf8sd_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder request queue
// Small FIFO of classified bytes between the front end and the decoder.
// ----------------------------------------------------------------------------
module utf8sd_queue
    import utf8sd_pkg::*;
#(
    parameter int DEPTH = UTF8SD_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cls_t push_cls,
    output logic pop_valid,
    input  logic pop_ready,
    output cls_t pop_cls
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cls_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cls    = entry_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cls;
        end
    end

endmodule

>>> hw/rtl/utf8sd_back.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder back end
// Runs the sequence state and registers one result per completed sequence or detected error.
// ----------------------------------------------------------------------------
module utf8sd_back
    import utf8sd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic pop_valid,
    output logic pop_ready,
    input  cls_t pop_cls,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_res
);

    logic [1:0]       rem_reg, rem_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [7:0]       lead_reg, lead_next;
    logic [CP_W-1:0]  partial_reg, partial_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    logic             pop;
    logic             emit;
    logic             second_byte;
    logic             range_bad;
    logic [1:0]       rem_dec;
    logic [CP_W-1:0]  partial_shift;

    assign pop_ready     = !out_valid_reg || m_ready;
    assign pop           = pop_valid & pop_ready;
    assign second_byte   = ({1'b0, rem_reg} + 3'd1) == total_reg;
    assign rem_dec       = rem_reg - 2'd1;
    assign partial_shift = {partial_reg[CP_W-7:0], pop_cls.data[5:0]};

    always_comb begin
        range_bad = 1'b0;
        if (second_byte) begin
            if (lead_reg == LEAD_E0 && pop_cls.data < MIN_AFTER_E0) begin
                range_bad = 1'b1;
            end
            if (lead_reg == LEAD_F0 && pop_cls.data < MIN_AFTER_F0) begin
                range_bad = 1'b1;
            end
            if (lead_reg == LEAD_F4 && pop_cls.data >= MAX_AFTER_F4) begin
                range_bad = 1'b1;
            end
        end
    end

    always_comb begin
        rem_next     = rem_reg;
        total_next   = total_reg;
        lead_next    = lead_reg;
        partial_next = partial_reg;
        emit         = 1'b0;
        res_next     = res_reg;

        if (pop) begin
            if (rem_reg == 2'd0) begin
                case (pop_cls.lead_len)
                    LEN_ONE: begin
                        emit                = 1'b1;
                        res_next.code_point = CP_W'(pop_cls.data);
                        res_next.seq_length = LEN_ONE;
                        res_next.error      = 1'b0;
                        res_next.error_kind = ERR_NONE;
                    end
                    LEN_TWO: begin
                        rem_next     = 2'd1;
                        total_next   = LEN_TWO;
                        lead_next    = pop_cls.data;
                        partial_next = CP_W'(pop_cls.data[4:0]);
                    end
                    LEN_THREE: begin
                        rem_next     = 2'd2;
                        total_next   = LEN_THREE;
                        lead_next    = pop_cls.data;
                        partial_next = CP_W'(pop_cls.data[3:0]);
                    end
                    LEN_FOUR: begin
                        rem_next     = 2'd3;
                        total_next   = LEN_FOUR;
                        lead_next    = pop_cls.data;
                        partial_next = CP_W'(pop_cls.data[2:0]);
                    end
                    default: begin
                        emit                = 1'b1;
                        res_next.code_point = '0;
                        res_next.seq_length = '0;
                        res_next.error      = 1'b1;
                        res_next.error_kind = ERR_LEAD;
                    end
                endcase
            end else if (!pop_cls.is_cont || range_bad) begin
                emit                = 1'b1;
                res_next.code_point = '0;
                res_next.seq_length = '0;
                res_next.error      = 1'b1;
                res_next.error_kind = pop_cls.is_cont ? ERR_RANGE : ERR_CONT;
                rem_next            = 2'd0;
                total_next          = '0;
                lead_next           = '0;
                partial_next        = '0;
            end else if (rem_dec == 2'd0) begin
                emit                = 1'b1;
                res_next.code_point = partial_shift;
                res_next.seq_length = total_reg;
                res_next.error      = 1'b0;
                res_next.error_kind = ERR_NONE;
                rem_next            = 2'd0;
                total_next          = '0;
                lead_next           = '0;
                partial_next        = '0;
            end else begin
                rem_next     = rem_dec;
                partial_next = partial_shift;
            end
        end

        if (pop) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg       <= '0;
            total_reg     <= '0;
            lead_reg      <= '0;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rem_reg       <= rem_next;
            total_reg     <= total_next;
            lead_reg      <= lead_next;
            partial_reg   <= partial_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid = out_valid_reg;
    assign m_res   = res_reg;

endmodule

>>> hw/rtl/utf8sd_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the decoder ports for result consistency and output stability.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_unit_macros.svh"

module utf8sd_checker
    import utf8sd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CP_W-1:0]  m_code_point,
    input logic [LEN_W-1:0] m_seq_length,
    input logic             m_error,
    input logic [ERR_W-1:0] m_error_kind
);

    logic [CP_W+LEN_W+ERR_W:0] out_word;
    logic                      err_shape_ok;
    logic                      ok_shape_ok;
    logic                      is_ascii_res;

    assign out_word     = {m_code_point, m_seq_length, m_error, m_error_kind};
    assign err_shape_ok = (m_code_point == '0) && (m_seq_length == '0) &&
                          (m_error_kind != ERR_NONE);
    assign ok_shape_ok  = (m_error_kind == ERR_NONE) && (m_seq_length != '0) &&
                          (m_seq_length <= LEN_FOUR);
    assign is_ascii_res = !m_error && (m_seq_length == LEN_ONE);

    `UTF8SD_ASSERT_NEXT_ALWAYS(a_reset_clears_out, aclk, !aresetn, !m_valid)
    `UTF8SD_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(out_word))
    `UTF8SD_ASSERT_IMPLY(a_error_zero, aclk, aresetn, m_valid && m_error, err_shape_ok)
    `UTF8SD_ASSERT_IMPLY(a_ok_fields, aclk, aresetn, m_valid && !m_error, ok_shape_ok)
    `UTF8SD_ASSERT_IMPLY(a_ascii_range, aclk, aresetn, m_valid && is_ascii_res, m_code_point < 21'h80)

endmodule

bind utf8_stream_decoder_unit utf8sd_checker u_utf8sd_checker (.*);
